[hw/rtl/fpdc_pkg.sv]
package fpdc_pkg;

  localparam int TIME_W        = 48;
  localparam int CNT_W         = 16;
  localparam int CODE_W        = 16;
  localparam int TIME_BITS_DEF = 48;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_PULSE = 2'd1,
    OP_ARM   = 2'd2,
    OP_ABORT = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_TARGET = 2'd1,
    EV_WARN   = 2'd2,
    EV_BUSY   = 2'd3
  } ev_t;

  localparam logic [CODE_W-1:0] CODE_OFFSET = 16'd1000;
  localparam logic [CNT_W-1:0]  HI_LIMIT    = 16'd199;
  localparam logic [CNT_W-1:0]  MID_LIMIT   = 16'd149;
  localparam logic [CNT_W-1:0]  TARGET_RST  = 16'd40;
  localparam logic [CNT_W-1:0]  WARN_RST    = 16'd40;

  localparam int PCT_W = 7;
  localparam logic [PCT_W-1:0] PCT_HI  = 7'd60;
  localparam logic [PCT_W-1:0] PCT_MID = 7'd84;
  localparam logic [PCT_W-1:0] PCT_LO  = 7'd89;

  // floor(x / 100) as (x * ceil(2^30 / 100)) >> 30, exact for x below 2^23
  localparam int PROD_W      = 23;
  localparam int RECIP_W     = 24;
  localparam int RECIP_SHIFT = 30;
  localparam logic [RECIP_W-1:0] RECIP_M = 24'd10737419;

  typedef struct packed {
    logic take;
    logic mul;
    logic scale;
    logic div;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic warn_job;
    logic div_job;
  } sts_t;

endpackage

[hw/rtl/fpdc_in_if.sv]
interface fpdc_in_if import fpdc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  logic [CODE_W-1:0] target_code;
  logic [TIME_W-1:0] now_us;

  modport source (output valid, opcode, target_code, now_us, input ready);
  modport sink   (input valid, opcode, target_code, now_us, output ready);
endinterface

[hw/rtl/fpdc_out_if.sv]
interface fpdc_out_if import fpdc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        event_res;
  logic              pulse_time_valid;
  logic [TIME_W-1:0] pulse_time_us;
  logic [CNT_W-1:0]  pulse_count;
  logic              checking;

  modport source (output valid, event_res, pulse_time_valid, pulse_time_us, pulse_count,
                  checking, input ready);
  modport sink   (input valid, event_res, pulse_time_valid, pulse_time_us, pulse_count,
                  checking, output ready);
endinterface

[hw/rtl/fpdc_ctrl.sv]
module fpdc_ctrl import fpdc_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam int ITERS = (TIME_BITS + 1) / 2;
  localparam int IT_W  = $clog2(ITERS);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MUL   = 5'b00010,
    S_SCALE = 5'b00100,
    S_DIV   = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t          state_r, state_nxt;
  logic [IT_W-1:0] iter_r, iter_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            take, emit;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign take      = (state_r == S_IDLE) && in_valid;
  assign emit      = (state_r == S_EMIT) && (!out_valid_r || out_ready);

  assign cmd.take  = take;
  assign cmd.mul   = (state_r == S_MUL);
  assign cmd.scale = (state_r == S_SCALE);
  assign cmd.div   = (state_r == S_DIV);
  assign cmd.emit  = emit;

  always_comb begin
    state_nxt     = state_r;
    iter_nxt      = iter_r;
    out_valid_nxt = emit | (out_valid_r & ~out_ready);
    case (state_r)
      S_IDLE: begin
        iter_nxt = IT_W'(ITERS - 1);
        if (in_valid) begin
          if (sts.warn_job) begin
            state_nxt = S_MUL;
          end else if (sts.div_job) begin
            state_nxt = S_DIV;
          end else begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_MUL:   state_nxt = S_SCALE;
      S_SCALE: state_nxt = S_EMIT;
      S_DIV: begin
        if (iter_r == '0) begin
          state_nxt = S_EMIT;
        end else begin
          iter_nxt = iter_r - 1'b1;
        end
      end
      S_EMIT: begin
        if (emit) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      iter_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iter_r      <= iter_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[hw/rtl/fpdc_dp.sv]
module fpdc_dp import fpdc_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic [1:0]        opcode,
  input  logic [CODE_W-1:0] target_code,
  input  logic [TIME_W-1:0] now_us,
  output logic [1:0]        event_res,
  output logic              pulse_time_valid,
  output logic [TIME_W-1:0] pulse_time_us,
  output logic [CNT_W-1:0]  pulse_count,
  output logic              checking
);

  localparam int ITERS = (TIME_BITS + 1) / 2;
  localparam int DW    = 2 * ITERS;
  localparam int SC_W  = PROD_W + RECIP_W;

  // dose state
  logic [CNT_W-1:0]     pulse_count_r, pulse_count_nxt;
  logic [CNT_W-1:0]     dose_target_r, dose_target_nxt;
  logic [CNT_W-1:0]     warn_level_r, warn_level_nxt;
  logic                 check_active_r, check_active_nxt;
  logic                 warn_armed_r, warn_armed_nxt;
  logic                 measure_armed_r, measure_armed_nxt;
  logic [TIME_BITS-1:0] start_time_r, start_time_nxt;

  // work registers
  logic [PROD_W-1:0]    prod_r, prod_nxt;
  logic [DW-1:0]        acc_r, acc_nxt;
  logic [CNT_W-1:0]     rem_r, rem_nxt;
  logic [CNT_W-1:0]     div_r, div_nxt;
  logic [1:0]           ev_r, ev_nxt;
  logic                 ptv_r, ptv_nxt;

  logic [1:0]           out_event_r;
  logic                 out_ptv_r;
  logic [TIME_W-1:0]    out_time_r;
  logic [CNT_W-1:0]     out_count_r;
  logic                 out_checking_r;

  logic [TIME_BITS-1:0] now_tb, elapsed;
  logic [CNT_W-1:0]     count_inc, code_sub;
  logic                 hit, warn_hit, code_warn;
  logic [PCT_W-1:0]     pct;
  logic [SC_W-1:0]      scaled;
  logic [CNT_W:0]       r1, r2;
  logic                 q1, q2;
  logic [CNT_W-1:0]     rem1, rem2;
  logic [DW-1:0]        a1, a2;

  assign now_tb    = TIME_BITS'(now_us);
  assign elapsed   = now_tb - start_time_r;
  assign count_inc = (pulse_count_r != '1) ? pulse_count_r + 1'b1 : pulse_count_r;
  assign hit       = check_active_r && (count_inc >= dose_target_r);
  assign warn_hit  = check_active_r && !hit && warn_armed_r && (count_inc >= warn_level_r);
  assign code_warn = (target_code >= CODE_OFFSET);
  assign code_sub  = target_code - CODE_OFFSET;

  assign sts.warn_job = (opcode == OP_LOAD) && !check_active_r && code_warn;
  assign sts.div_job  = (opcode == OP_PULSE) && hit && measure_armed_r;

  always_comb begin
    if (dose_target_r > HI_LIMIT) begin
      pct = PCT_HI;
    end else if (dose_target_r > MID_LIMIT) begin
      pct = PCT_MID;
    end else begin
      pct = PCT_LO;
    end
  end

  assign scaled = SC_W'(prod_r) * SC_W'(RECIP_M);

  // two restoring steps per cycle
  always_comb begin
    r1   = {rem_r, acc_r[DW-1]};
    q1   = (r1 >= {1'b0, div_r});
    rem1 = q1 ? CNT_W'(r1 - {1'b0, div_r}) : r1[CNT_W-1:0];
    a1   = {acc_r[DW-2:0], q1};
    r2   = {rem1, a1[DW-1]};
    q2   = (r2 >= {1'b0, div_r});
    rem2 = q2 ? CNT_W'(r2 - {1'b0, div_r}) : r2[CNT_W-1:0];
    a2   = {a1[DW-2:0], q2};
  end

  always_comb begin
    pulse_count_nxt   = pulse_count_r;
    dose_target_nxt   = dose_target_r;
    warn_level_nxt    = warn_level_r;
    check_active_nxt  = check_active_r;
    warn_armed_nxt    = warn_armed_r;
    measure_armed_nxt = measure_armed_r;
    start_time_nxt    = start_time_r;
    prod_nxt          = prod_r;
    acc_nxt           = acc_r;
    rem_nxt           = rem_r;
    div_nxt           = div_r;
    ev_nxt            = ev_r;
    ptv_nxt           = ptv_r;
    if (cmd.take) begin
      ev_nxt  = EV_NONE;
      ptv_nxt = 1'b0;
      case (opcode)
        OP_LOAD: begin
          if (check_active_r) begin
            ev_nxt = EV_BUSY;
          end else begin
            if (code_warn) begin
              dose_target_nxt = code_sub;
            end else begin
              dose_target_nxt = target_code;
              warn_level_nxt  = '0;
              warn_armed_nxt  = 1'b0;
            end
            pulse_count_nxt  = '0;
            check_active_nxt = 1'b1;
            if (measure_armed_r) begin
              start_time_nxt = now_tb;
            end
          end
        end
        OP_PULSE: begin
          pulse_count_nxt = count_inc;
          if (hit) begin
            ev_nxt           = EV_TARGET;
            check_active_nxt = 1'b0;
            if (measure_armed_r) begin
              measure_armed_nxt = 1'b0;
              ptv_nxt           = 1'b1;
              acc_nxt           = DW'(elapsed);
              rem_nxt           = '0;
              div_nxt           = (dose_target_r == '0) ? CNT_W'(1) : dose_target_r;
            end
          end else if (warn_hit) begin
            ev_nxt         = EV_WARN;
            warn_armed_nxt = 1'b0;
          end
        end
        OP_ARM:   measure_armed_nxt = 1'b1;
        OP_ABORT: check_active_nxt  = 1'b0;
        default:  ev_nxt = EV_NONE;
      endcase
    end
    if (cmd.mul) begin
      prod_nxt = PROD_W'(dose_target_r) * PROD_W'(pct);
    end
    if (cmd.scale) begin
      warn_level_nxt = scaled[RECIP_SHIFT +: CNT_W];
      warn_armed_nxt = (scaled[RECIP_SHIFT +: CNT_W] != '0);
    end
    if (cmd.div) begin
      acc_nxt = a2;
      rem_nxt = rem2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_count_r   <= '0;
      dose_target_r   <= TARGET_RST;
      warn_level_r    <= WARN_RST;
      check_active_r  <= 1'b0;
      warn_armed_r    <= 1'b0;
      measure_armed_r <= 1'b0;
      start_time_r    <= '0;
    end else begin
      pulse_count_r   <= pulse_count_nxt;
      dose_target_r   <= dose_target_nxt;
      warn_level_r    <= warn_level_nxt;
      check_active_r  <= check_active_nxt;
      warn_armed_r    <= warn_armed_nxt;
      measure_armed_r <= measure_armed_nxt;
      start_time_r    <= start_time_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
    ev_r   <= ev_nxt;
    ptv_r  <= ptv_nxt;
    if (cmd.emit) begin
      out_event_r    <= ev_r;
      out_ptv_r      <= ptv_r;
      out_time_r     <= ptv_r ? TIME_W'(acc_r) : '0;
      out_count_r    <= pulse_count_r;
      out_checking_r <= check_active_r;
    end
  end

  assign event_res        = out_event_r;
  assign pulse_time_valid = out_ptv_r;
  assign pulse_time_us    = out_time_r;
  assign pulse_count      = out_count_r;
  assign checking         = out_checking_r;

endmodule

[hw/rtl/flow_pulse_dose_counter_core.sv]
// channel  | modport | moves per transfer
// in_ch    | sink    | opcode, target_code, now_us
// out_ch   | source  | event_res, pulse_time_valid, pulse_time_us, pulse_count, checking
//
// an item goes from the idle state to the emit state and then into the output register; a load with
// early warning first passes through percentage multiply, then reciprocal scale by 1/100
// a pulse that reaches the target with measurement armed first passes through the divider, which
// retires two quotient bits a cycle
// synchronous reset clears count and flags, target and warning level return to 40
// one item at a time; the next item is taken while a result waits in the output register,
// and its own result then holds until that register is free
module flow_pulse_dose_counter_core import fpdc_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  fpdc_in_if.sink    in_ch,
  fpdc_out_if.source out_ch
);

  cmd_t cmd;
  sts_t sts;

  fpdc_ctrl #(
    .TIME_BITS (TIME_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fpdc_dp #(
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .opcode           (in_ch.opcode),
    .target_code      (in_ch.target_code),
    .now_us           (in_ch.now_us),
    .event_res        (out_ch.event_res),
    .pulse_time_valid (out_ch.pulse_time_valid),
    .pulse_time_us    (out_ch.pulse_time_us),
    .pulse_count      (out_ch.pulse_count),
    .checking         (out_ch.checking)
  );

endmodule
